/* hdl/gbb_pkg.sv */
// Shared types and constants of the glyph bitmap blitter.
package gbb_pkg;

   localparam int COORD_W     = 12;
   localparam int LINE_W      = 16;
   localparam int ROW_OFF_W   = COORD_W + LINE_W;
   localparam int CSR_INDEX_W = 3;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam logic [7:0] FB_DEPTH_8     = 8'd8;
   localparam logic [7:0] FB_DEPTH_16    = 8'd16;
   localparam logic [7:0] FB_DEPTH_32    = 8'd32;
   localparam logic [7:0] GLYPH_DEPTH_1  = 8'd1;
   localparam logic [7:0] GLYPH_DEPTH_8  = 8'd8;
   localparam logic [7:0] FB_DEPTH_RESET = FB_DEPTH_16;
   localparam logic [31:0] FORE_RESET    = 32'h00ff_ffff;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FRAME_BASE = 3'd0,
      CSR_LINE_BYTES = 3'd1,
      CSR_FB_DEPTH   = 3'd2,
      CSR_FORE_COLOR = 3'd3,
      CSR_BACK_COLOR = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      ERR_NONE        = 2'd0,
      ERR_FB_DEPTH    = 2'd1,
      ERR_GLYPH_DEPTH = 2'd2
   } err_type;

   typedef enum logic {
      ACT_BEGIN = 1'b0,
      ACT_DATA  = 1'b1
   } action_type;

   typedef struct packed {
      logic [31:0]       frame_base;
      logic [LINE_W-1:0] line_bytes;
      logic [7:0]        fb_depth;
      logic [31:0]       fore_color;
      logic [31:0]       back_color;
   } cfg_type;

   // One unit of work for the back end: an error result or a run of 1 to 8 pixels.
   typedef struct packed {
      err_type              err;
      logic [ROW_OFF_W-1:0] row_off;
      logic [COORD_W-1:0]   col;
      logic [2:0]           last_idx;
      logic [7:0]           bits;
   } job_type;

endpackage

/* hdl/gbb_front.sv */
// Front end: accepts requests, tracks the glyph raster position and issues jobs.
module gbb_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_action,
   input  logic [gbb_pkg::COORD_W-1:0] req_x_left,
   input  logic [gbb_pkg::COORD_W-1:0] req_y_top,
   input  logic [gbb_pkg::COORD_W-1:0] req_x_end,
   input  logic [gbb_pkg::COORD_W-1:0] req_y_end,
   input  logic [7:0]               req_row_pitch,
   input  logic [7:0]               req_glyph_depth,
   input  logic [7:0]               req_data_byte,
   input  gbb_pkg::cfg_type         cfg,
   input  logic                     q_full,
   output logic                     q_push,
   output gbb_pkg::job_type         q_job
);

   logic [gbb_pkg::COORD_W-1:0] left_col_ff, left_col_in;
   logic [gbb_pkg::COORD_W-1:0] end_col_ff, end_col_in;
   logic [gbb_pkg::COORD_W-1:0] end_row_ff, end_row_in;
   logic [gbb_pkg::COORD_W-1:0] cur_col_ff, cur_col_in;
   logic [gbb_pkg::COORD_W-1:0] cur_row_ff, cur_row_in;
   logic [7:0] pitch_ff, pitch_in;
   logic [7:0] bytes_in_row_ff, bytes_in_row_in;
   logic       byte_mode_ff, byte_mode_in;
   logic       active_ff, active_in;

   logic                        accept;
   logic                        fb_ok;
   logic                        has_pixels;
   logic [gbb_pkg::COORD_W:0]   col_diff;
   logic [3:0]                  run_len;
   logic [gbb_pkg::COORD_W-1:0] next_col;
   logic [gbb_pkg::COORD_W-1:0] next_row;
   logic [7:0]                  bytes_next;
   logic                        row_done;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;
   assign fb_ok     = (cfg.fb_depth == gbb_pkg::FB_DEPTH_8) ||
                      (cfg.fb_depth == gbb_pkg::FB_DEPTH_16) ||
                      (cfg.fb_depth == gbb_pkg::FB_DEPTH_32);
   assign has_pixels = cur_col_ff < end_col_ff;
   assign col_diff   = {1'b0, end_col_ff} - {1'b0, cur_col_ff};
   assign next_row   = cur_row_ff + 1'b1;
   assign bytes_next = (bytes_in_row_ff == 8'hff) ? 8'hff : bytes_in_row_ff + 8'd1;

   always_comb begin
      left_col_in     = left_col_ff;
      end_col_in      = end_col_ff;
      end_row_in      = end_row_ff;
      cur_col_in      = cur_col_ff;
      cur_row_in      = cur_row_ff;
      pitch_in        = pitch_ff;
      bytes_in_row_in = bytes_in_row_ff;
      byte_mode_in    = byte_mode_ff;
      active_in       = active_ff;
      q_push          = 1'b0;
      q_job.err       = gbb_pkg::ERR_NONE;
      q_job.row_off   = cur_row_ff * cfg.line_bytes;
      q_job.col       = cur_col_ff;
      q_job.last_idx  = 3'd0;
      q_job.bits      = req_data_byte;
      run_len         = 4'd0;
      next_col        = cur_col_ff;
      row_done        = 1'b0;

      if (!has_pixels) begin
         run_len = 4'd0;
      end else if (col_diff > (gbb_pkg::COORD_W + 1)'(8)) begin
         run_len = 4'd8;
      end else begin
         run_len = col_diff[3:0];
      end

      if (accept) begin
         if (req_action == gbb_pkg::ACT_BEGIN) begin
            left_col_in     = req_x_left;
            cur_col_in      = req_x_left;
            end_col_in      = req_x_end;
            cur_row_in      = req_y_top;
            end_row_in      = req_y_end;
            pitch_in        = req_row_pitch;
            bytes_in_row_in = 8'd0;
            byte_mode_in    = (req_glyph_depth == gbb_pkg::GLYPH_DEPTH_8);
            if ((req_glyph_depth != gbb_pkg::GLYPH_DEPTH_1) &&
                (req_glyph_depth != gbb_pkg::GLYPH_DEPTH_8)) begin
               active_in = 1'b0;
               q_push    = 1'b1;
               q_job.err = gbb_pkg::ERR_GLYPH_DEPTH;
            end else begin
               active_in = (req_x_left < req_x_end) && (req_y_top < req_y_end);
            end
         end else if (active_ff) begin
            if (has_pixels && !fb_ok) begin
               active_in = 1'b0;
               q_push    = 1'b1;
               q_job.err = gbb_pkg::ERR_FB_DEPTH;
            end else if (byte_mode_ff) begin
               q_push     = 1'b1;
               q_job.bits = {(req_data_byte != 8'd0), 7'd0};
               next_col   = cur_col_ff + 1'b1;
               cur_col_in = next_col;
               row_done   = next_col >= end_col_ff;
            end else begin
               q_push          = run_len != 4'd0;
               q_job.last_idx  = 3'(run_len - 4'd1);
               next_col        = cur_col_ff + gbb_pkg::COORD_W'(run_len);
               cur_col_in      = next_col;
               bytes_in_row_in = bytes_next;
               row_done        = (next_col >= end_col_ff) && (bytes_next >= pitch_ff);
            end
            if (row_done) begin
               cur_row_in      = next_row;
               cur_col_in      = left_col_ff;
               bytes_in_row_in = 8'd0;
               if (next_row >= end_row_ff) begin
                  active_in = 1'b0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_col_ff     <= '0;
         end_col_ff      <= '0;
         end_row_ff      <= '0;
         cur_col_ff      <= '0;
         cur_row_ff      <= '0;
         pitch_ff        <= '0;
         bytes_in_row_ff <= '0;
         byte_mode_ff    <= 1'b0;
         active_ff       <= 1'b0;
      end else begin
         left_col_ff     <= left_col_in;
         end_col_ff      <= end_col_in;
         end_row_ff      <= end_row_in;
         cur_col_ff      <= cur_col_in;
         cur_row_ff      <= cur_row_in;
         pitch_ff        <= pitch_in;
         bytes_in_row_ff <= bytes_in_row_in;
         byte_mode_ff    <= byte_mode_in;
         active_ff       <= active_in;
      end
   end

endmodule

/* hdl/gbb_queue.sv */
// Small job queue between the front end and the back end.
module gbb_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  gbb_pkg::job_type push_job,
   output logic             full,
   input  logic             pop,
   output logic             head_valid,
   output gbb_pkg::job_type head_job
);

   gbb_pkg::job_type entry_ff [gbb_pkg::QUEUE_DEPTH];
   logic [gbb_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [gbb_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [gbb_pkg::QPTR_W:0]   count_ff, count_in;

   assign full       = count_ff == (gbb_pkg::QPTR_W + 1)'(gbb_pkg::QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head_job   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* hdl/gbb_back.sv */
// Back end: steps through each job and drives one response per cycle while responses are taken.
module gbb_back (
   input  logic             clock,
   input  logic             reset,
   input  gbb_pkg::cfg_type cfg,
   input  logic             q_valid,
   input  gbb_pkg::job_type q_job,
   output logic             q_pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [31:0]      rsp_pixel_addr,
   output logic [31:0]      rsp_pixel_data,
   output logic [2:0]       rsp_byte_count,
   output logic             rsp_write_enable,
   output logic [1:0]       rsp_error_code,
   output logic             rsp_last
);

   gbb_pkg::job_type job_ff, job_in;
   logic       job_valid_ff, job_valid_in;
   logic [2:0] idx_ff, idx_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] addr_ff, addr_in;
   logic [31:0] data_ff, data_in;
   logic [2:0]  count_ff, count_in;
   logic        we_ff, we_in;
   logic [1:0]  err_ff, err_in;
   logic        last_ff, last_in;

   logic        slot_free;
   logic        fire;
   logic        finish;
   logic [31:0] color;
   logic [31:0] col_off;
   logic [31:0] pix_data;
   logic [2:0]  pix_count;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign fire      = job_valid_ff && slot_free;
   assign finish    = fire && ((job_ff.err != gbb_pkg::ERR_NONE) || (idx_ff == job_ff.last_idx));
   assign q_pop     = q_valid && (!job_valid_ff || finish);
   assign color     = job_ff.bits[7] ? cfg.fore_color : cfg.back_color;

   always_comb begin
      case (cfg.fb_depth)
         gbb_pkg::FB_DEPTH_8: begin
            col_off   = {{(32 - gbb_pkg::COORD_W){1'b0}}, job_ff.col};
            pix_data  = {24'd0, color[7:0]};
            pix_count = 3'd1;
         end
         gbb_pkg::FB_DEPTH_16: begin
            col_off   = {{(31 - gbb_pkg::COORD_W){1'b0}}, job_ff.col, 1'b0};
            pix_data  = {16'd0, color[23:19], color[15:10], color[7:3]};
            pix_count = 3'd2;
         end
         default: begin
            col_off   = {{(30 - gbb_pkg::COORD_W){1'b0}}, job_ff.col, 2'b00};
            pix_data  = color;
            pix_count = 3'd4;
         end
      endcase
   end

   always_comb begin
      job_in       = job_ff;
      job_valid_in = job_valid_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      addr_in      = addr_ff;
      data_in      = data_ff;
      count_in     = count_ff;
      we_in        = we_ff;
      err_in       = err_ff;
      last_in      = last_ff;

      if (fire) begin
         rsp_valid_in = 1'b1;
         err_in       = job_ff.err;
         last_in      = finish;
         if (job_ff.err != gbb_pkg::ERR_NONE) begin
            addr_in  = 32'd0;
            data_in  = 32'd0;
            count_in = 3'd0;
            we_in    = 1'b0;
         end else begin
            addr_in  = cfg.frame_base + {{(32 - gbb_pkg::ROW_OFF_W){1'b0}}, job_ff.row_off}
                       + col_off;
            data_in  = pix_data;
            count_in = pix_count;
            we_in    = 1'b1;
         end
         idx_in      = idx_ff + 3'd1;
         job_in.col  = job_ff.col + 1'b1;
         job_in.bits = {job_ff.bits[6:0], 1'b0};
      end

      if (q_pop) begin
         job_in       = q_job;
         job_valid_in = 1'b1;
         idx_in       = 3'd0;
      end else if (finish) begin
         job_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      job_ff   <= job_in;
      idx_ff   <= idx_in;
      addr_ff  <= addr_in;
      data_ff  <= data_in;
      count_ff <= count_in;
      we_ff    <= we_in;
      err_ff   <= err_in;
      last_ff  <= last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         job_valid_ff <= job_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pixel_addr   = addr_ff;
   assign rsp_pixel_data   = data_ff;
   assign rsp_byte_count   = count_ff;
   assign rsp_write_enable = we_ff;
   assign rsp_error_code   = err_ff;
   assign rsp_last         = last_ff;

endmodule

/* hdl/glyph_bitmap_blitter_top.sv */
// Top level of the glyph bitmap blitter: registers, front end, job queue and back end.
// A request is taken whenever the four-entry job queue has room; the back end then drives
// one response per cycle, so a 1 bpp bitmap byte yields one response per pixel it covers
// (up to 8), an 8 bpp byte or an error one response, and valid begin requests and padding
// bytes yield none. Sustained throughput is set by the back end's pixel sequencer at one
// pixel write per cycle while responses are taken. There is no clearing pass after reset.
module glyph_bitmap_blitter_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [gbb_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [31:0]                        csr_wdata,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_action,
   input  logic [gbb_pkg::COORD_W-1:0]        req_x_left,
   input  logic [gbb_pkg::COORD_W-1:0]        req_y_top,
   input  logic [gbb_pkg::COORD_W-1:0]        req_x_end,
   input  logic [gbb_pkg::COORD_W-1:0]        req_y_end,
   input  logic [7:0]                         req_row_pitch,
   input  logic [7:0]                         req_glyph_depth,
   input  logic [7:0]                         req_data_byte,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [31:0]                        rsp_pixel_addr,
   output logic [31:0]                        rsp_pixel_data,
   output logic [2:0]                         rsp_byte_count,
   output logic                               rsp_write_enable,
   output logic [1:0]                         rsp_error_code,
   output logic                               rsp_last
);

   gbb_pkg::cfg_type cfg_ff, cfg_in;
   gbb_pkg::job_type push_job;
   gbb_pkg::job_type head_job;
   logic q_full, q_push, q_pop, q_valid;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            gbb_pkg::CSR_FRAME_BASE: cfg_in.frame_base = csr_wdata;
            gbb_pkg::CSR_LINE_BYTES: cfg_in.line_bytes = csr_wdata[gbb_pkg::LINE_W-1:0];
            gbb_pkg::CSR_FB_DEPTH:   cfg_in.fb_depth   = csr_wdata[7:0];
            gbb_pkg::CSR_FORE_COLOR: cfg_in.fore_color = csr_wdata;
            gbb_pkg::CSR_BACK_COLOR: cfg_in.back_color = csr_wdata;
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_base <= '0;
         cfg_ff.line_bytes <= '0;
         cfg_ff.fb_depth   <= gbb_pkg::FB_DEPTH_RESET;
         cfg_ff.fore_color <= gbb_pkg::FORE_RESET;
         cfg_ff.back_color <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   gbb_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_action      (req_action),
      .req_x_left      (req_x_left),
      .req_y_top       (req_y_top),
      .req_x_end       (req_x_end),
      .req_y_end       (req_y_end),
      .req_row_pitch   (req_row_pitch),
      .req_glyph_depth (req_glyph_depth),
      .req_data_byte   (req_data_byte),
      .cfg             (cfg_ff),
      .q_full          (q_full),
      .q_push          (q_push),
      .q_job           (push_job)
   );

   gbb_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_job   (push_job),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_job   (head_job)
   );

   gbb_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .q_valid          (q_valid),
      .q_job            (head_job),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_pixel_addr   (rsp_pixel_addr),
      .rsp_pixel_data   (rsp_pixel_data),
      .rsp_byte_count   (rsp_byte_count),
      .rsp_write_enable (rsp_write_enable),
      .rsp_error_code   (rsp_error_code),
      .rsp_last         (rsp_last)
   );

endmodule

/* sim/tb_top.sv */
// Self-checking testbench of the glyph bitmap blitter: directed table, then random glyph phases.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LATENCY_WAIT = 16;
   localparam int RANDOM_ITEMS = 125;
   localparam int TAIL_ITEMS   = 100;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      gbb_pkg::action_type         action;
      logic [gbb_pkg::COORD_W-1:0] x_left;
      logic [gbb_pkg::COORD_W-1:0] y_top;
      logic [gbb_pkg::COORD_W-1:0] x_end;
      logic [gbb_pkg::COORD_W-1:0] y_end;
      logic [7:0]                  row_pitch;
      logic [7:0]                  glyph_depth;
      logic [7:0]                  data_byte;
   } blit_req_type;

   typedef struct packed {
      logic [31:0] addr;
      logic [31:0] data;
      logic [2:0]  count;
      logic        we;
      logic [1:0]  err;
      logic        last;
   } pixel_write_type;

   typedef struct {
      bit                     is_csr;
      gbb_pkg::csr_index_type csr_sel;
      logic [31:0]            csr_val;
      blit_req_type           req;
      bit                     has_lit;
      pixel_write_type        lit;
   } table_row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_we = 1'b0;
   logic [gbb_pkg::CSR_INDEX_W-1:0] csr_index = gbb_pkg::CSR_FRAME_BASE;
   logic [31:0]        csr_wdata = '0;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic               req_action = gbb_pkg::ACT_BEGIN;
   logic [gbb_pkg::COORD_W-1:0] req_x_left = '0;
   logic [gbb_pkg::COORD_W-1:0] req_y_top = '0;
   logic [gbb_pkg::COORD_W-1:0] req_x_end = '0;
   logic [gbb_pkg::COORD_W-1:0] req_y_end = '0;
   logic [7:0]         req_row_pitch = '0;
   logic [7:0]         req_glyph_depth = '0;
   logic [7:0]         req_data_byte = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [31:0]        rsp_pixel_addr;
   logic [31:0]        rsp_pixel_data;
   logic [2:0]         rsp_byte_count;
   logic               rsp_write_enable;
   logic [1:0]         rsp_error_code;
   logic               rsp_last;

   glyph_bitmap_blitter_top dut (.*);

   gbb_pkg::cfg_type   shadow_cfg;
   logic [gbb_pkg::COORD_W-1:0] glyph_left, glyph_end_col, glyph_end_row, pos_col, pos_row;
   logic [7:0]         glyph_pitch, row_bytes;
   bit                 glyph_bytewise, glyph_live;

   pixel_write_type pixels_now[$];
   pixel_write_type expected_pixels[$];
   table_row_type   stim_table[$];
   int              fail_count = 0;
   int              blit_items = 0;
   bit              calm = 1'b0;
   int              stall_left = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #5_000_000;
      $display("Test completed with failures");
      $finish;
   end

   function automatic pixel_write_type status_write(gbb_pkg::err_type code);
      pixel_write_type res;
      res = '0;
      res.err = code;
      return res;
   endfunction

   function automatic pixel_write_type pixel_write(bit lit_on);
      pixel_write_type res;
      logic [31:0] color, step_size;
      color = lit_on ? shadow_cfg.fore_color : shadow_cfg.back_color;
      step_size = 32'(shadow_cfg.fb_depth) >> 3;
      res = '0;
      res.addr = shadow_cfg.frame_base + 32'(pos_row) * 32'(shadow_cfg.line_bytes)
                 + 32'(pos_col) * step_size;
      res.we = 1'b1;
      res.err = gbb_pkg::ERR_NONE;
      if (shadow_cfg.fb_depth == gbb_pkg::FB_DEPTH_8) begin
         res.data = {24'd0, color[7:0]};
         res.count = 3'd1;
      end else if (shadow_cfg.fb_depth == gbb_pkg::FB_DEPTH_16) begin
         res.data = {16'd0, color[23:19], color[15:10], color[7:3]};
         res.count = 3'd2;
      end else begin
         res.data = color;
         res.count = 3'd4;
      end
      return res;
   endfunction

   function automatic void advance_row();
      pos_row = pos_row + 1'b1;
      pos_col = glyph_left;
      row_bytes = '0;
      if (pos_row >= glyph_end_row) glyph_live = 1'b0;
   endfunction

   // Fills pixels_now with the writes that one request causes; an ignored one leaves it empty.
   function automatic void predict_blit(blit_req_type r);
      bit depth_ok;
      int bit_idx;
      pixels_now.delete();
      depth_ok = shadow_cfg.fb_depth == gbb_pkg::FB_DEPTH_8
                 || shadow_cfg.fb_depth == gbb_pkg::FB_DEPTH_16
                 || shadow_cfg.fb_depth == gbb_pkg::FB_DEPTH_32;
      if (r.action == gbb_pkg::ACT_BEGIN) begin
         glyph_left = r.x_left;
         pos_col = r.x_left;
         glyph_end_col = r.x_end;
         pos_row = r.y_top;
         glyph_end_row = r.y_end;
         glyph_pitch = r.row_pitch;
         row_bytes = '0;
         glyph_bytewise = r.glyph_depth == gbb_pkg::GLYPH_DEPTH_8;
         if (r.glyph_depth != gbb_pkg::GLYPH_DEPTH_1 &&
             r.glyph_depth != gbb_pkg::GLYPH_DEPTH_8) begin
            glyph_live = 1'b0;
            pixels_now.push_back(status_write(gbb_pkg::ERR_GLYPH_DEPTH));
         end else begin
            glyph_live = (r.x_left < r.x_end) && (r.y_top < r.y_end);
         end
      end else if (!glyph_live) begin
         return;
      end else if (pos_col < glyph_end_col && !depth_ok) begin
         glyph_live = 1'b0;
         pixels_now.push_back(status_write(gbb_pkg::ERR_FB_DEPTH));
      end else if (glyph_bytewise) begin
         pixels_now.push_back(pixel_write(r.data_byte != 8'd0));
         pos_col = pos_col + 1'b1;
         if (pos_col >= glyph_end_col) advance_row();
      end else begin
         for (bit_idx = 7; bit_idx >= 0 && pos_col < glyph_end_col; bit_idx--) begin
            pixels_now.push_back(pixel_write(r.data_byte[bit_idx]));
            pos_col = pos_col + 1'b1;
         end
         if (row_bytes != 8'hff) row_bytes = row_bytes + 1'b1;
         if (pos_col >= glyph_end_col && row_bytes >= glyph_pitch) advance_row();
      end
      if (pixels_now.size() > 0) pixels_now[pixels_now.size()-1].last = 1'b1;
   endfunction

   function automatic blit_req_type mk_begin(int xl, int yt, int xe, int ye, int pitch,
                                             int depth);
      blit_req_type r;
      r = '0;
      r.action = gbb_pkg::ACT_BEGIN;
      r.x_left = gbb_pkg::COORD_W'(xl);
      r.y_top = gbb_pkg::COORD_W'(yt);
      r.x_end = gbb_pkg::COORD_W'(xe);
      r.y_end = gbb_pkg::COORD_W'(ye);
      r.row_pitch = 8'(pitch);
      r.glyph_depth = 8'(depth);
      r.data_byte = 8'($urandom_range(0, 255));
      return r;
   endfunction

   function automatic blit_req_type mk_data(int value);
      blit_req_type r;
      r = '0;
      r.action = gbb_pkg::ACT_DATA;
      r.x_left = gbb_pkg::COORD_W'($urandom_range(0, 4095));
      r.x_end = gbb_pkg::COORD_W'($urandom_range(0, 4095));
      r.row_pitch = 8'($urandom_range(0, 255));
      r.data_byte = 8'(value);
      return r;
   endfunction

   function automatic table_row_type blank_row();
      table_row_type row;
      row.is_csr = 1'b0;
      row.csr_sel = gbb_pkg::CSR_FRAME_BASE;
      row.csr_val = '0;
      row.req = '0;
      row.has_lit = 1'b0;
      row.lit = '0;
      return row;
   endfunction

   function automatic void table_req(blit_req_type r);
      table_row_type row;
      row = blank_row();
      row.req = r;
      stim_table.push_back(row);
   endfunction

   function automatic void table_check(blit_req_type r, pixel_write_type lit);
      table_row_type row;
      row = blank_row();
      row.req = r;
      row.has_lit = 1'b1;
      row.lit = lit;
      stim_table.push_back(row);
   endfunction

   function automatic void table_csr(gbb_pkg::csr_index_type sel, logic [31:0] val);
      table_row_type row;
      row = blank_row();
      row.is_csr = 1'b1;
      row.csr_sel = sel;
      row.csr_val = val;
      stim_table.push_back(row);
   endfunction

   task automatic note_failure(string msg);
      fail_count++;
      if (fail_count <= REPORT_LIMIT) $display("%s", msg);
   endtask

   task automatic push_request(blit_req_type r, bit has_lit, pixel_write_type lit);
      if (!calm && blit_items < TAIL_ITEMS && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= r.action;
      req_x_left <= r.x_left;
      req_y_top <= r.y_top;
      req_x_end <= r.x_end;
      req_y_end <= r.y_end;
      req_row_pitch <= r.row_pitch;
      req_glyph_depth <= r.glyph_depth;
      req_data_byte <= r.data_byte;
      do @(posedge clock); while (!req_ready);
      predict_blit(r);
      blit_items++;
      if (has_lit) expected_pixels.push_back(lit);
      else foreach (pixels_now[i]) expected_pixels.push_back(pixels_now[i]);
   endtask

   task automatic quiesce();
      req_valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (LATENCY_WAIT) @(posedge clock);
   endtask

   task automatic program_reg(gbb_pkg::csr_index_type sel, logic [31:0] val);
      csr_we <= 1'b1;
      csr_index <= sel;
      csr_wdata <= val;
      @(posedge clock);
      case (sel)
         gbb_pkg::CSR_FRAME_BASE: shadow_cfg.frame_base = val;
         gbb_pkg::CSR_LINE_BYTES: shadow_cfg.line_bytes = val[gbb_pkg::LINE_W-1:0];
         gbb_pkg::CSR_FB_DEPTH:   shadow_cfg.fb_depth = val[7:0];
         gbb_pkg::CSR_FORE_COLOR: shadow_cfg.fore_color = val;
         gbb_pkg::CSR_BACK_COLOR: shadow_cfg.back_color = val;
         default: ;
      endcase
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic random_config();
      int pick;
      if ($urandom_range(0, 1) == 0) begin
         pick = $urandom_range(0, 3);
         program_reg(gbb_pkg::CSR_FRAME_BASE, pick == 0 ? 32'd0 : pick == 1 ? '1 : $urandom);
      end
      if ($urandom_range(0, 1) == 0) begin
         pick = $urandom_range(0, 3);
         program_reg(gbb_pkg::CSR_LINE_BYTES, pick == 0 ? 32'd0 : pick == 1 ? 32'hffff
                                              : $urandom_range(0, 65535));
      end
      if ($urandom_range(0, 1) == 0) begin
         pick = $urandom_range(0, 6);
         program_reg(gbb_pkg::CSR_FB_DEPTH,
                     pick < 2 ? 32'(gbb_pkg::FB_DEPTH_8) : pick < 4 ? 32'(gbb_pkg::FB_DEPTH_16)
                     : pick < 6 ? 32'(gbb_pkg::FB_DEPTH_32) : $urandom_range(0, 255));
      end
      if ($urandom_range(0, 1) == 0) program_reg(gbb_pkg::CSR_FORE_COLOR, $urandom);
      if ($urandom_range(0, 1) == 0) program_reg(gbb_pkg::CSR_BACK_COLOR, $urandom);
   endtask

   task automatic random_glyph();
      int w, h, xl, yt, xe, ye, depth, pitch, needed, total, shape, pick;
      shape = $urandom_range(0, 9);
      if (shape == 0) begin
         repeat ($urandom_range(1, 3)) push_request(mk_data($urandom_range(0, 255)), 0, '0);
         push_request(mk_begin($urandom_range(0, 4095), $urandom_range(0, 4095),
                               $urandom_range(0, 4095), $urandom_range(0, 4095),
                               $urandom_range(0, 255), $urandom_range(0, 255)), 0, '0);
         repeat ($urandom_range(0, 4)) push_request(mk_data($urandom_range(0, 255)), 0, '0);
         return;
      end
      w = $urandom_range(1, 16);
      h = $urandom_range(1, 3);
      xl = $urandom_range(0, 4095);
      yt = $urandom_range(0, 4095);
      xe = (xl + w > 4095) ? 4095 : xl + w;
      ye = (yt + h > 4095) ? 4095 : yt + h;
      pick = $urandom_range(0, 19);
      depth = pick < 9 ? int'(gbb_pkg::GLYPH_DEPTH_1) : pick < 18 ? int'(gbb_pkg::GLYPH_DEPTH_8)
                                                              : $urandom_range(0, 255);
      needed = (xe - xl + 7) / 8;
      pitch = (shape == 1) ? $urandom_range(0, 12) : $urandom_range(0, needed + 2);
      if (depth == gbb_pkg::GLYPH_DEPTH_8) total = (xe - xl) * (ye - yt);
      else total = (ye - yt) * ((pitch > needed) ? pitch : needed);
      if (shape <= 2) total = $urandom_range(0, total < 12 ? total : 12);
      else total = total + $urandom_range(0, 1);
      push_request(mk_begin(xl, yt, xe, ye, pitch, depth), 0, '0);
      repeat (total)
         push_request(mk_data($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 255)), 0, '0);
   endtask

   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left = stall_left - 1;
      end else if (!calm && blit_items < TAIL_ITEMS && $urandom_range(0, 7) == 0) begin
         rsp_ready <= 1'b0;
         stall_left = $urandom_range(0, 5);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : check_rsp
      pixel_write_type got, want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_pixel_addr, rsp_pixel_data, rsp_byte_count, rsp_write_enable,
                rsp_error_code, rsp_last};
         if (expected_pixels.size() == 0) begin
            note_failure($sformatf("unexpected response addr=%h data=%h cnt=%0d we=%b err=%0d last=%b",
                                   got.addr, got.data, got.count, got.we, got.err, got.last));
         end else begin
            want = expected_pixels.pop_front();
            if (got.addr !== want.addr || got.data !== want.data || got.count !== want.count
                || got.we !== want.we || got.err !== want.err || got.last !== want.last) begin
               note_failure($sformatf({"mismatch: expected addr=%h data=%h cnt=%0d we=%b ",
                                       "err=%0d last=%b, got addr=%h data=%h cnt=%0d we=%b ",
                                       "err=%0d last=%b"},
                                      want.addr, want.data, want.count, want.we, want.err,
                                      want.last, got.addr, got.data, got.count, got.we,
                                      got.err, got.last));
            end
         end
      end
   end

   initial begin : stimulus
      shadow_cfg = '{frame_base: 32'd0, line_bytes: '0, fb_depth: gbb_pkg::FB_DEPTH_RESET,
                     fore_color: gbb_pkg::FORE_RESET, back_color: 32'd0};
      glyph_left = '0;
      glyph_end_col = '0;
      glyph_end_row = '0;
      pos_col = '0;
      pos_row = '0;
      glyph_pitch = '0;
      row_bytes = '0;
      glyph_bytewise = 1'b0;
      glyph_live = 1'b0;

      table_req(mk_begin(0, 0, 1, 1, 0, gbb_pkg::GLYPH_DEPTH_8));
      table_check(mk_data(8'hff),
                  '{32'h0, 32'h0000_ffff, 3'd2, 1'b1, gbb_pkg::ERR_NONE, 1'b1});
      table_req(mk_data(8'h55));
      table_check(mk_begin(0, 0, 4, 4, 1, 0),
                  '{32'h0, 32'h0, 3'd0, 1'b0, gbb_pkg::ERR_GLYPH_DEPTH, 1'b1});
      table_check(mk_begin(4095, 4095, 4095, 4095, 255, 255),
                  '{32'h0, 32'h0, 3'd0, 1'b0, gbb_pkg::ERR_GLYPH_DEPTH, 1'b1});
      table_csr(gbb_pkg::CSR_FRAME_BASE, 32'hffff_fff0);
      table_csr(gbb_pkg::CSR_LINE_BYTES, 32'h0000_ffff);
      table_csr(gbb_pkg::CSR_FB_DEPTH, 32'(gbb_pkg::FB_DEPTH_32));
      table_csr(gbb_pkg::CSR_FORE_COLOR, 32'hffff_ffff);
      table_csr(gbb_pkg::CSR_BACK_COLOR, 32'h1234_5678);
      table_req(mk_begin(4090, 4094, 4095, 4095, 2, gbb_pkg::GLYPH_DEPTH_1));
      table_req(mk_data(8'ha5));
      table_req(mk_data(8'h00));
      table_req(mk_begin(5, 0, 5, 10, 0, gbb_pkg::GLYPH_DEPTH_1));
      table_req(mk_data(8'h3c));
      table_req(mk_begin(0, 100, 8, 50, 0, gbb_pkg::GLYPH_DEPTH_8));
      table_req(mk_begin(0, 0, 12, 2, 0, gbb_pkg::GLYPH_DEPTH_1));
      table_req(mk_data(8'hff));
      table_req(mk_data(8'h0f));
      table_req(mk_data(8'hf0));
      table_req(mk_data(8'h33));
      table_csr(gbb_pkg::CSR_FB_DEPTH, 32'(gbb_pkg::FB_DEPTH_8));
      table_req(mk_begin(3, 7, 5, 9, 255, gbb_pkg::GLYPH_DEPTH_8));
      table_req(mk_data(8'h00));
      table_req(mk_data(8'h01));
      table_req(mk_data(8'h80));
      table_req(mk_data(8'hff));
      table_csr(gbb_pkg::CSR_FB_DEPTH, 32'd24);
      table_req(mk_begin(0, 0, 2, 1, 1, gbb_pkg::GLYPH_DEPTH_1));
      table_check(mk_data(8'h80),
                  '{32'h0, 32'h0, 3'd0, 1'b0, gbb_pkg::ERR_FB_DEPTH, 1'b1});
      table_req(mk_data(8'h7e));

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (stim_table[i]) begin
         if (stim_table[i].is_csr) begin
            quiesce();
            program_reg(stim_table[i].csr_sel, stim_table[i].csr_val);
         end else begin
            push_request(stim_table[i].req, stim_table[i].has_lit, stim_table[i].lit);
         end
      end

      blit_items = 0;
      while (blit_items < RANDOM_ITEMS) begin
         calm = $urandom_range(0, 3) == 0;
         quiesce();
         random_config();
         repeat ($urandom_range(2, 5)) begin
            if (blit_items < RANDOM_ITEMS) random_glyph();
         end
      end

      quiesce();
      if (fail_count == 0 && expected_pixels.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

/* files.f */
hdl/gbb_pkg.sv
hdl/gbb_front.sv
hdl/gbb_queue.sv
hdl/gbb_back.sv
hdl/glyph_bitmap_blitter_top.sv
sim/tb_top.sv
